// File: rtl/rdx_pkg.sv
// rdx_pkg: shared widths, constants, job type and helpers of the radix digit emitter.
// No dependencies; every rtl/ file imports it.
package rdx_pkg;

  localparam int VALUE_W     = 32;               // converted value width
  localparam int BASE_W      = 6;                // base register width
  localparam int CHAR_W      = 7;                // ASCII code width
  localparam int DIG_W       = BASE_W;           // one digit value, below 36
  localparam int BIT_W       = 3;                // index of a digit bit, 0..5
  localparam int IDX_W       = $clog2(VALUE_W);  // digit place, 0..VALUE_W-1
  localparam int PROD_W      = VALUE_W + BASE_W; // power times base
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;               // APB data width
  localparam int ADDR_W      = 3;                // APB address width

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [DIG_W-1:0]  DIG_TEN    = DIG_W'(10);
  localparam logic [CHAR_W-1:0] ASCII_NUM  = CHAR_W'(48);  // '0'
  localparam logic [CHAR_W-1:0] ASCII_ALPH = CHAR_W'(55);  // 'A' - 10

  localparam logic [ADDR_W-1:0] REG_BASE_ADDR = ADDR_W'(0);

  // One conversion job, as handed from the front to the back.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [BASE_W-1:0]  base;
    logic [BIT_W-1:0]   top_bit;  // highest bit a digit of this base can have
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Highest set bit position of (base - 1), for base 2..36.
  function automatic logic [BIT_W-1:0] top_bit_of(input logic [BASE_W-1:0] b);
    logic [BIT_W-1:0] r;
    begin
      if (b > BASE_W'(32))      r = BIT_W'(5);
      else if (b > BASE_W'(16)) r = BIT_W'(4);
      else if (b > BASE_W'(8))  r = BIT_W'(3);
      else if (b > BASE_W'(4))  r = BIT_W'(2);
      else if (b > BASE_W'(2))  r = BIT_W'(1);
      else                      r = BIT_W'(0);
      return r;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] r;
    begin
      if (d >= DIG_TEN) r = CHAR_W'(d) + ASCII_ALPH;
      else              r = CHAR_W'(d) + ASCII_NUM;
      return r;
    end
  endfunction

endpackage

// File: rtl/rdx_front.sv
// rdx_front: input register; clamps the base and classifies the job.
// Depends on rdx_pkg.
module rdx_front import rdx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [BASE_W-1:0]  base_cfg,
  input  queue_stat_t        q_stat,
  output job_push_t          push
);

  logic         valid_r, valid_nxt;
  job_t         job_r, job_nxt;
  logic [BASE_W-1:0] eff_base;
  logic         take, drain;

  always_comb begin
    if (base_cfg < BASE_MIN)      eff_base = BASE_MIN;
    else if (base_cfg > BASE_MAX) eff_base = BASE_MAX;
    else                          eff_base = base_cfg;
  end

  assign drain = valid_r & ~q_stat.full;
  assign busy  = valid_r & q_stat.full;
  assign take  = start & ~busy;

  always_comb begin
    valid_nxt = valid_r;
    job_nxt   = job_r;
    if (drain) valid_nxt = 1'b0;
    if (take) begin
      valid_nxt       = 1'b1;
      job_nxt.value   = in_value;
      job_nxt.base    = eff_base;
      job_nxt.top_bit = top_bit_of(eff_base);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    job_r <= job_nxt;
  end

  assign push.valid = drain;
  assign push.job   = job_r;

  a_busy_only_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> valid_r && q_stat.full)
    else $error("busy without a held job");
  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r && job_r.base >= BASE_MIN && job_r.base <= BASE_MAX)
    else $error("accepted job not held or base out of range");
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> valid_r && $stable(job_r))
    else $error("held job changed while queue full");

endmodule

// File: rtl/rdx_queue.sv
// rdx_queue: small register FIFO of jobs between front and back.
// Depends on rdx_pkg.
module rdx_queue import rdx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  job_push_t   push,
  input  logic        pop,
  output job_t        head,
  output queue_stat_t q_stat
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_pop       = pop & ~q_stat.empty;
  assign head         = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push.valid)
      wr_nxt = (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    if (do_pop)
      rd_nxt = (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    if (push.valid && !do_pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push.valid && do_pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push.valid) mem_r[wr_r] <= push.job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_stat.full)
    else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of bounds");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.empty || q_stat.full) |-> wr_r == rd_r)
    else $error("queue pointers disagree with count");

endmodule

// File: rtl/rdx_back.sv
// rdx_back: digit engine; builds the power ladder, then peels digits MSB first.
// Depends on rdx_pkg.
module rdx_back import rdx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              head,
  input  queue_stat_t       q_stat,
  output logic              pop,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_digit_char,
  output logic              out_last_digit
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RISE = 3'b010,
    S_DIG  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [VALUE_W-1:0] pw_r, pw_nxt;
  logic [VALUE_W-1:0] pw_stack_r [VALUE_W];
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [BIT_W-1:0]   top_r, top_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt, dig_cur;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_wa;
  logic [VALUE_W-1:0] stk_wd;
  logic [PROD_W-1:0]  prod, trial;
  logic               fits;
  logic               ov_nxt, last_nxt;
  logic [CHAR_W-1:0]  char_nxt;
  logic               out_valid_r, out_last_r;
  logic [CHAR_W-1:0]  out_char_r;

  assign prod  = PROD_W'(pw_r) * PROD_W'(base_r);
  assign trial = PROD_W'(pw_r) << bit_r;
  assign fits  = PROD_W'(rem_r) >= trial;
  assign dig_cur = fits ? (dig_r | (DIG_W'(1) << bit_r)) : dig_r;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    pw_nxt    = pw_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    top_nxt   = top_r;
    bit_nxt   = bit_r;
    dig_nxt   = dig_r;
    stk_we    = 1'b0;
    stk_wa    = idx_r;
    stk_wd    = pw_r;
    pop       = 1'b0;
    ov_nxt    = 1'b0;
    last_nxt  = 1'b0;
    char_nxt  = to_ascii(dig_cur);
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          rem_nxt   = head.value;
          base_nxt  = head.base;
          top_nxt   = head.top_bit;
          pw_nxt    = VALUE_W'(1);
          idx_nxt   = '0;
          stk_we    = 1'b1;
          stk_wa    = '0;
          stk_wd    = VALUE_W'(1);
          state_nxt = S_RISE;
        end
      end
      S_RISE: begin
        if (prod <= PROD_W'(rem_r)) begin
          pw_nxt  = prod[VALUE_W-1:0];
          idx_nxt = idx_r + IDX_W'(1);
          stk_we  = 1'b1;
          stk_wa  = idx_r + IDX_W'(1);
          stk_wd  = prod[VALUE_W-1:0];
        end else begin
          bit_nxt   = top_r;
          dig_nxt   = '0;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (fits) rem_nxt = rem_r - trial[VALUE_W-1:0];
        dig_nxt = dig_cur;
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          ov_nxt   = 1'b1;
          last_nxt = (idx_r == '0);
          dig_nxt  = '0;
          bit_nxt  = top_r;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
            pw_nxt  = pw_stack_r[idx_r - IDX_W'(1)];
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ov_nxt;
    end
    rem_r      <= rem_nxt;
    pw_r       <= pw_nxt;
    idx_r      <= idx_nxt;
    base_r     <= base_nxt;
    top_r      <= top_nxt;
    bit_r      <= bit_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= char_nxt;
    out_last_r <= last_nxt;
    if (stk_we) pw_stack_r[stk_wa] <= stk_wd;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  // greedy invariant: what is left fits in the digit bits still to be decided
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIG |->
      {7'b0, rem_r} < ({7'b0, pw_r} << ({1'b0, bit_r} + 4'd1)))
    else $error("remainder exceeds current place");
  a_emit_from_dig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DIG))
    else $error("digit emitted outside digit phase");
  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> state_r == S_IDLE)
    else $error("final digit emitted while job still running");
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r >= ASCII_NUM && out_char_r <= CHAR_W'(57)) ||
                    (out_char_r >= CHAR_W'(65) && out_char_r <= CHAR_W'(90)))
    else $error("digit code outside 0-9 / A-Z");

endmodule

// File: rtl/radix_to_ascii_digits_core.sv
// radix_to_ascii_digits_core: top level of the radix digit emitter.
// Depends on rdx_pkg, rdx_front, rdx_queue, rdx_back.
//
//  channel | ports                               | transfer when
//  --------+-------------------------------------+------------------------------
//  input   | start, busy, in_value               | start high, busy low
//  result  | out_valid, out_digit_char,          | every cycle out_valid is high
//          | out_last_digit                      | (one cycle, no backpressure)
//  config  | psel penable pwrite paddr pwdata    | psel, penable, pwrite high
//          | prdata pready                       | (pready tied high)
//
// Flow: a value passes the input register, then the queue, on its way to the
// digit engine. The engine loads the job, builds the power ladder and then
// decides the digits, most significant first, each in B = ceil(log2(base))
// restoring-subtract steps, one step for each bit of the digit.
// Reset (rst_n low, synchronous) empties the queue and idles the engine;
// base returns to 10. busy rises only when the input register and the
// two-entry queue are both full; results are never stalled.
module radix_to_ascii_digits_core import rdx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  // result channel
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [BASE_W-1:0] cfg_base_r, cfg_base_nxt;
  logic              cfg_wr;
  job_push_t         push;
  queue_stat_t       q_stat;
  job_t              head;
  logic              pop;

  // Register file: only base, decoded on the word address bit.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    cfg_base_nxt = cfg_base_r;
    if (cfg_wr && paddr[ADDR_W-1] == REG_BASE_ADDR[ADDR_W-1])
      cfg_base_nxt = pwdata[BASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= BASE_RESET;
    end else begin
      cfg_base_r <= cfg_base_nxt;
    end
  end

  // read data: base at word 0, zero elsewhere
  assign prdata = (paddr[ADDR_W-1] == REG_BASE_ADDR[ADDR_W-1]) ?
                  DATA_W'(cfg_base_r) : '0;

  rdx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .base_cfg (cfg_base_r),
    .q_stat   (q_stat),
    .push     (push)
  );

  rdx_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  rdx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && paddr[ADDR_W-1] == 1'b0 |=> cfg_base_r == $past(pwdata[BASE_W-1:0]))
    else $error("base register write lost");
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !q_stat.empty)
    else $error("busy while queue empty");
  a_pop_when_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("engine took a job from an empty queue");

endmodule

// File: tb/radix_digit_monitor.sv
// radix_digit_monitor: watches the value, digit and register channels of the radix
// digit emitter, predicts the digit stream and compares it field by field.
// Depends on rdx_pkg only.
`timescale 1ns / 1ps

module radix_digit_monitor import rdx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic [CHAR_W-1:0]  out_digit_char,
  input  logic               out_last_digit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int unsigned        n_errors,
  output int unsigned        n_pending,
  output int unsigned        n_values,
  output int unsigned        n_digits
);

  localparam int unsigned SHOW_MAX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } digit_t;

  logic [BASE_W-1:0] base_reg = BASE_RESET;
  digit_t            expected_digits[$];
  digit_t            got;
  digit_t            want;
  int unsigned       errs   = 0;
  int unsigned       values = 0;
  int unsigned       digits = 0;

  // Appends the digits of v, most significant first, in the current base.
  function automatic void queue_digits_of(input logic [VALUE_W-1:0] v);
    int unsigned       radix;
    logic [VALUE_W-1:0] rest;
    logic [DIG_W-1:0]  d;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] chars[$];
    digit_t            e;
    radix = 32'(base_reg);
    if (base_reg < BASE_MIN) radix = 32'(BASE_MIN);
    if (base_reg > BASE_MAX) radix = 32'(BASE_MAX);
    rest = v;
    do begin
      d    = DIG_W'(rest % radix);
      rest = rest / radix;
      if (d >= DIG_TEN) c = ASCII_ALPH + CHAR_W'(d);
      else              c = ASCII_NUM + CHAR_W'(d);
      chars.push_front(c);
    end while (rest != 0);
    foreach (chars[i]) begin
      e.ch      = chars[i];
      e.is_last = (i == chars.size() - 1);
      expected_digits.push_back(e);
    end
  endfunction

  function automatic void flag(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
    if (errs < SHOW_MAX)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    errs++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      base_reg = BASE_RESET;
      expected_digits.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[ADDR_W-1] == REG_BASE_ADDR[ADDR_W-1])
        base_reg = pwdata[BASE_W-1:0];
      if (start && !busy) begin
        queue_digits_of(in_value);
        values++;
      end
      if (out_valid) begin
        got.ch      = out_digit_char;
        got.is_last = out_last_digit;
        if (expected_digits.size() == 0) begin
          flag("digit with nothing expected", 0, 32'(got.ch));
        end else begin
          want = expected_digits.pop_front();
          if (got.ch !== want.ch) flag("digit_char", 32'(want.ch), 32'(got.ch));
          if (got.is_last !== want.is_last)
            flag("last_digit", 32'(want.is_last), 32'(got.is_last));
          digits++;
        end
      end
    end
    n_errors  <= errs;
    n_pending <= expected_digits.size();
    n_values  <= values;
    n_digits  <= digits;
  end

endmodule

// File: tb/tb_radix_to_ascii_digits_core.sv
// tb_radix_to_ascii_digits_core: stimulus and verdict for the radix digit emitter.
// Depends on rdx_pkg, radix_to_ascii_digits_core and radix_digit_monitor.
`timescale 1ns / 1ps

module tb_radix_to_ascii_digits_core;
  import rdx_pkg::*;

  localparam int NUM_RANDOM = 108;  // random values after the directed part
  localparam int PHASE_LEN  = 16;   // values per base setting in the random part
  localparam int CALM_TAIL  = 30;   // last values go back to back, no sender gaps
  localparam int DRAIN_PAD  = 8;    // settle time before a register write
  localparam int END_PAD    = 80;   // idle cycles after the final drain

  // index 1 of the register map: nothing lives there, writes must be dropped
  localparam logic [ADDR_W-1:0] REG_SPARE_ADDR = ADDR_W'(4);

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [ADDR_W-1:0]  paddr   = '0;
  logic [DATA_W-1:0]  pwdata  = '0;

  logic               busy;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last_digit;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int unsigned        n_errors;
  int unsigned        n_pending;
  int unsigned        n_values;
  int unsigned        n_digits;
  int unsigned        n_bases = 0;

  always #2 clk = ~clk;

  radix_to_ascii_digits_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  radix_digit_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .n_errors       (n_errors),
    .n_pending      (n_pending),
    .n_values       (n_values),
    .n_digits       (n_digits)
  );

  // One value transfer. An optional idle gap comes first, with junk on
  // in_value so only the accepted word matters. start is left high afterwards:
  // the next call either raises a gap or keeps it high, so start never sees two
  // nonblocking writes in one step. busy is read right after the edge, i.e. the
  // value it had when the edge sampled start.
  task automatic send_value(input logic [VALUE_W-1:0] v, input bit allow_gap);
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      start    <= 1'b0;
      in_value <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender until every predicted digit has come out. The first edge
  // lets the monitor log a transfer taken at the current edge; the pad covers
  // the engine winding down after its last digit.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands on the edge with pready high.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Base change on an idle block. Bits above the 6-bit field carry junk,
  // which the block has to drop.
  task automatic set_base(input logic [BASE_W-1:0] raw);
    drain();
    write_reg(REG_BASE_ADDR, (DATA_W'($urandom) & ~DATA_W'(6'h3F)) | DATA_W'(raw));
    n_bases++;
  endtask

  // Mix of full-width words, small numbers, powers of two (and one below) and
  // shifted words so every digit count shows up in every base.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom_range(0, 255);
      1:       v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      2:       v = (VALUE_W'(1) << $urandom_range(1, VALUE_W - 1)) - 1'b1;
      3:       v = $urandom_range(0, 99999);
      4:       v = VALUE_W'($urandom) >> $urandom_range(0, VALUE_W - 1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    logic [BASE_W-1:0] b;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset base of ten, zero, one, digit rollover, full scale.
    send_value(32'd0, 1'b0);
    send_value(32'd1, 1'b0);
    send_value(32'd9, 1'b0);
    send_value(32'd10, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'd1_000_000_000, 1'b0);
    send_value(32'd999_999_999, 1'b0);

    // Base two: longest digit strings.
    set_base(BASE_MIN);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'd0, 1'b0);
    send_value(32'd1, 1'b0);
    send_value(32'h8000_0000, 1'b0);

    // Base thirty-six: highest letter 'Z' and the first two-digit number.
    set_base(BASE_MAX);
    send_value(32'd35, 1'b0);
    send_value(32'd36, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'd0, 1'b0);

    // Base below two clamps up to two.
    set_base(6'd0);
    send_value(32'd5, 1'b0);
    set_base(6'd1);
    send_value(32'd6, 1'b0);

    // Base above thirty-six clamps down to thirty-six.
    set_base(6'd37);
    send_value(32'd35, 1'b0);
    set_base(6'd63);
    send_value(32'd1295, 1'b0);

    // Base eleven: first letter 'A'.
    set_base(6'd11);
    send_value(32'd10, 1'b0);

    // Hex, then a write to the unused index must leave the base at sixteen.
    set_base(6'd16);
    send_value(32'hDEAD_BEEF, 1'b0);
    drain();
    write_reg(REG_SPARE_ADDR, 32'd7);
    send_value(32'hCAFE_F00D, 1'b0);

    // Random part: a new base every PHASE_LEN values, extremes first; each
    // base change drains the block, which also holds the sender off until
    // every digit is out. The tail runs without sender gaps or base changes.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % PHASE_LEN == 0 && i < NUM_RANDOM - CALM_TAIL) begin
        case (i / PHASE_LEN)
          0:       b = BASE_MIN;
          1:       b = BASE_MAX;
          2:       b = 6'd0;
          3:       b = 6'd63;
          default: b = BASE_W'($urandom_range(0, 63));
        endcase
        if ($urandom_range(0, 1) == 1) begin
          drain();
          write_reg(REG_SPARE_ADDR, $urandom);
        end
        set_base(b);
      end
      send_value(pick_value(), i < NUM_RANDOM - CALM_TAIL);
    end

    drain();
    repeat (END_PAD) @(posedge clk);

    $display("Converted %0d values over %0d base settings (clamped and junk-topped",
             n_values, n_bases);
    $display("writes included), %0d digit characters compared", n_digits);
    if (n_errors == 0 && n_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: the slowest correct run, about 130 values plus drains, is far
  // below this.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
